// File: hw/rtl/bea_pkg.sv
// ----------------------------------------------------------------------------
// bea_pkg
// Shared constants, codes and control types of the bitmap extent allocator.
// ----------------------------------------------------------------------------
package bea_pkg;

    localparam int GROUP_MAX = 8192;
    localparam int WORD_BITS = 64;
    localparam int MAP_WORDS = GROUP_MAX / WORD_BITS;
    localparam int WORD_AW   = $clog2(MAP_WORDS);
    localparam int BIT_AW    = $clog2(WORD_BITS);
    localparam int LANES     = 8;
    localparam int CHUNKS    = WORD_BITS / LANES;
    localparam int CHUNK_AW  = $clog2(CHUNKS);
    localparam int LANE_AW   = $clog2(LANES);
    localparam int CNT_W     = 14;
    localparam int POS_W     = 13;
    localparam logic [CNT_W-1:0] CNT_MAX   = 14'h3FFF;
    localparam logic [CNT_W-1:0] GROUP_DEF = 14'd8192;

    localparam logic [2:0] OP_ALLOC    = 3'd0;
    localparam logic [2:0] OP_FREE     = 3'd1;
    localparam logic [2:0] OP_RESCAN   = 3'd2;
    localparam logic [2:0] OP_COMMIT   = 3'd3;
    localparam logic [2:0] OP_ROLLBACK = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_RANGE    = 2'd1;
    localparam logic [1:0] ST_CONFLICT = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_CHK_RD, S_CHK_EV, S_WR_RD, S_WR_EV, S_UPDATE,
        S_SCAN_RD, S_SCAN_LD, S_SCAN_CH, S_SCAN_END, S_DONE
    } state_t;

    typedef enum logic [3:0] {
        ACT_NONE, ACT_ACCEPT, ACT_DECODE, ACT_CHK_RD, ACT_CHK_EV, ACT_WR_RD,
        ACT_WR_EV, ACT_UPDATE, ACT_SCAN_RD, ACT_SCAN_LD, ACT_SCAN_CH,
        ACT_SCAN_END, ACT_LOAD_OUT
    } act_t;

    typedef struct packed {
        act_t act;
    } cmd_t;

    typedef struct packed {
        logic op_alloc;
        logic op_free;
        logic op_rescan;
        logic trivial;
        logic range_bad;
        logic hit;
        logic word_last;
        logic chunk_last;
        logic scan_last;
        logic need_scan;
        logic out_busy;
    } stat_t;

endpackage

// File: hw/rtl/bea_if.sv
// ----------------------------------------------------------------------------
// bea_in_if / bea_out_if
// Valid/ready channels for operation beats and result beats.
// ----------------------------------------------------------------------------
interface bea_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [12:0] range_start;
    logic [13:0] range_length;

    modport source (output valid, output op, output range_start, output range_length,
                    input ready);
    modport sink (input valid, input op, input range_start, input range_length,
                  output ready);
endinterface

interface bea_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [13:0] free_count;
    logic [13:0] first_free_hint;
    logic [13:0] best_start;
    logic [13:0] best_length;

    modport source (output valid, output status, output free_count,
                    output first_free_hint, output best_start, output best_length,
                    input ready);
    modport sink (input valid, input status, input free_count,
                  input first_free_hint, input best_start, input best_length,
                  output ready);
endinterface

// File: hw/rtl/bea_ram.sv
// ----------------------------------------------------------------------------
// bea_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bea_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hw/rtl/bea_ctrl.sv
// ----------------------------------------------------------------------------
// bea_ctrl
// Sequencer: check pass, write pass, counter update and bitmap scan.
// ----------------------------------------------------------------------------
module bea_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  bea_pkg::stat_t st,
    output bea_pkg::cmd_t  cmd
);

    bea_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bea_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bea_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = bea_pkg::S_DECODE;
                end
            end
            bea_pkg::S_DECODE:
            begin
                if (st.op_alloc || st.op_free)
                begin
                    if (st.trivial || st.range_bad)
                    begin
                        state_next = bea_pkg::S_DONE;
                    end
                    else
                    begin
                        state_next = bea_pkg::S_CHK_RD;
                    end
                end
                else if (st.op_rescan)
                begin
                    state_next = bea_pkg::S_SCAN_RD;
                end
                else
                begin
                    state_next = bea_pkg::S_DONE;
                end
            end
            bea_pkg::S_CHK_RD: state_next = bea_pkg::S_CHK_EV;
            bea_pkg::S_CHK_EV:
            begin
                if (st.hit)
                begin
                    state_next = bea_pkg::S_DONE;
                end
                else if (st.word_last)
                begin
                    state_next = bea_pkg::S_WR_RD;
                end
                else
                begin
                    state_next = bea_pkg::S_CHK_RD;
                end
            end
            bea_pkg::S_WR_RD: state_next = bea_pkg::S_WR_EV;
            bea_pkg::S_WR_EV:
            begin
                if (st.word_last)
                begin
                    state_next = bea_pkg::S_UPDATE;
                end
                else
                begin
                    state_next = bea_pkg::S_WR_RD;
                end
            end
            bea_pkg::S_UPDATE:
            begin
                if (st.need_scan)
                begin
                    state_next = bea_pkg::S_SCAN_RD;
                end
                else
                begin
                    state_next = bea_pkg::S_DONE;
                end
            end
            bea_pkg::S_SCAN_RD: state_next = bea_pkg::S_SCAN_LD;
            bea_pkg::S_SCAN_LD: state_next = bea_pkg::S_SCAN_CH;
            bea_pkg::S_SCAN_CH:
            begin
                if (st.scan_last)
                begin
                    state_next = bea_pkg::S_SCAN_END;
                end
                else if (st.chunk_last)
                begin
                    state_next = bea_pkg::S_SCAN_RD;
                end
            end
            bea_pkg::S_SCAN_END: state_next = bea_pkg::S_DONE;
            bea_pkg::S_DONE:
            begin
                if (!st.out_busy)
                begin
                    state_next = bea_pkg::S_IDLE;
                end
            end
            default: state_next = bea_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd.act  = bea_pkg::ACT_NONE;
        case (state_reg)
            bea_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.act = bea_pkg::ACT_ACCEPT;
                end
            end
            bea_pkg::S_DECODE:   cmd.act = bea_pkg::ACT_DECODE;
            bea_pkg::S_CHK_RD:   cmd.act = bea_pkg::ACT_CHK_RD;
            bea_pkg::S_CHK_EV:   cmd.act = bea_pkg::ACT_CHK_EV;
            bea_pkg::S_WR_RD:    cmd.act = bea_pkg::ACT_WR_RD;
            bea_pkg::S_WR_EV:    cmd.act = bea_pkg::ACT_WR_EV;
            bea_pkg::S_UPDATE:   cmd.act = bea_pkg::ACT_UPDATE;
            bea_pkg::S_SCAN_RD:  cmd.act = bea_pkg::ACT_SCAN_RD;
            bea_pkg::S_SCAN_LD:  cmd.act = bea_pkg::ACT_SCAN_LD;
            bea_pkg::S_SCAN_CH:  cmd.act = bea_pkg::ACT_SCAN_CH;
            bea_pkg::S_SCAN_END: cmd.act = bea_pkg::ACT_SCAN_END;
            bea_pkg::S_DONE:
            begin
                if (!st.out_busy)
                begin
                    cmd.act = bea_pkg::ACT_LOAD_OUT;
                end
            end
            default: cmd.act = bea_pkg::ACT_NONE;
        endcase
    end

endmodule

// File: hw/rtl/bea_dp.sv
// ----------------------------------------------------------------------------
// bea_dp
// Datapath: bitmap RAM, range masks, counters, run scanner and result register.
// ----------------------------------------------------------------------------
module bea_dp (
    input  logic          clk,
    input  logic          rst_n,
    input  bea_pkg::cmd_t  cmd,
    output bea_pkg::stat_t st,
    input  logic          cfg_we,
    input  logic [13:0]   cfg_wdata,
    input  logic [2:0]    op,
    input  logic [12:0]   range_start,
    input  logic [13:0]   range_length,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [1:0]    status,
    output logic [13:0]   free_count,
    output logic [13:0]   first_free_hint,
    output logic [13:0]   best_start,
    output logic [13:0]   best_length
);

    localparam int CW = bea_pkg::CNT_W;
    localparam int WB = bea_pkg::WORD_BITS;
    localparam int AW = bea_pkg::WORD_AW;

    function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [CW-1:0] b);
        logic [CW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, bea_pkg::CNT_MAX}) ? bea_pkg::CNT_MAX : s[CW-1:0];
    endfunction

    function automatic logic [CW-1:0] sat_sub(input logic [CW-1:0] a, input logic [CW-1:0] b);
        return (a > b) ? a - b : '0;
    endfunction

    // input beat and configuration
    logic [2:0]    op_reg;
    logic [12:0]   start_reg;
    logic [CW-1:0] len_reg;
    logic [CW:0]   end_reg;
    logic [CW-1:0] gb_reg;
    logic [CW-1:0] n;
    logic [CW:0]   end_m1;
    logic [AW-1:0] ws, we;

    // counters, live and saved
    logic [CW-1:0] free_reg, first_reg, lbeg_reg, llen_reg;
    logic [CW-1:0] sv_free_reg, sv_first_reg, sv_lbeg_reg, sv_llen_reg;
    logic [1:0]    stat_reg;

    // sequencing
    logic [AW-1:0]               word_reg;
    logic [bea_pkg::CHUNK_AW-1:0] chunk_reg;
    logic [WB-1:0]               buf_reg;

    // scanner state
    logic [CW-1:0] cs_reg, cl_reg, bs_reg, bl_reg, cnt_reg, fb_reg, es_reg, el_reg;
    logic          found_reg;
    logic [CW-1:0] cs_n, cl_n, bs_n, bl_n, cnt_n, fb_n, es_n, el_n;
    logic          found_n;

    // bitmap storage
    logic [bea_pkg::MAP_WORDS-1:0] vld_reg;
    logic          rd_vld_reg;
    logic          ram_we, ram_re;
    logic [WB-1:0] ram_wdata, ram_rdata, word_data, mask;

    // output register
    logic          ov_reg;
    logic [1:0]    o_stat_reg;
    logic [CW-1:0] o_free_reg, o_first_reg, o_beg_reg, o_len_reg;

    // counter update results
    logic [CW-1:0] a_free, a_first, a_lbeg, a_llen;
    logic          a_touch;
    logic [CW-1:0] f_free, f_first, f_lbeg, f_llen;
    logic          f_search;
    logic [CW:0]   ls15, le15, s15, df, ds;

    logic          op_alloc, op_free, op_rescan;
    logic [CW-1:0] next_base;

    assign n        = (gb_reg > bea_pkg::GROUP_DEF) ? bea_pkg::GROUP_DEF : gb_reg;
    assign end_m1   = end_reg - 1'b1;
    assign ws       = start_reg[bea_pkg::POS_W-1:bea_pkg::BIT_AW];
    assign we       = end_m1[bea_pkg::POS_W-1:bea_pkg::BIT_AW];
    assign op_alloc = (op_reg == bea_pkg::OP_ALLOC);
    assign op_free  = (op_reg == bea_pkg::OP_FREE);
    assign op_rescan = (op_reg == bea_pkg::OP_RESCAN);

    bea_ram #(
        .WIDTH (WB),
        .DEPTH (bea_pkg::MAP_WORDS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (word_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (word_reg),
        .rdata (ram_rdata)
    );

    // never-written words read as all free
    assign word_data = rd_vld_reg ? ram_rdata : '0;
    assign ram_re = (cmd.act == bea_pkg::ACT_CHK_RD) || (cmd.act == bea_pkg::ACT_WR_RD) ||
                    (cmd.act == bea_pkg::ACT_SCAN_RD);
    assign ram_we = (cmd.act == bea_pkg::ACT_WR_EV);
    assign ram_wdata = op_alloc ? (word_data | mask) : (word_data & ~mask);

    // range mask inside the current word
    always_comb
    begin
        logic [CW:0] wbase;
        logic [CW:0] pos;
        wbase = {2'b0, word_reg, {bea_pkg::BIT_AW{1'b0}}};
        for (int b = 0; b < WB; b++)
        begin
            pos = wbase + (CW+1)'(b);
            mask[b] = (pos >= {2'b0, start_reg}) && (pos < end_reg);
        end
    end

    // allocate heuristic
    always_comb
    begin
        ls15 = {1'b0, lbeg_reg};
        le15 = ls15 + {1'b0, llen_reg};
        s15  = {2'b0, start_reg};
        df   = s15 - ls15;
        ds   = (le15 > end_reg) ? le15 - end_reg : '0;
        a_free  = sat_sub(free_reg, len_reg);
        a_first = first_reg;
        a_lbeg  = lbeg_reg;
        a_llen  = llen_reg;
        a_touch = 1'b1;
        if (s15 == ls15)
        begin
            if (first_reg == lbeg_reg)
            begin
                a_first = sat_add(first_reg, len_reg);
            end
            a_lbeg = sat_add(lbeg_reg, len_reg);
            a_llen = sat_sub(llen_reg, len_reg);
        end
        else if (end_reg == le15)
        begin
            a_llen = sat_sub(llen_reg, len_reg);
        end
        else if ((s15 < le15) && (s15 > ls15))
        begin
            if (df >= ds)
            begin
                a_llen = df[CW-1:0];
            end
            else
            begin
                a_llen = ds[CW-1:0];
                a_lbeg = end_reg[CW-1:0];
            end
        end
        else
        begin
            a_touch = 1'b0;
        end
    end

    // free merge
    always_comb
    begin
        f_free   = sat_add(free_reg, len_reg);
        f_first  = (first_reg > {1'b0, start_reg}) ? {1'b0, start_reg} : first_reg;
        f_lbeg   = lbeg_reg;
        f_llen   = llen_reg;
        f_search = 1'b0;
        if (end_reg == ls15)
        begin
            f_lbeg = {1'b0, start_reg};
            f_llen = sat_add(llen_reg, len_reg);
        end
        else if (s15 == le15)
        begin
            f_llen = sat_add(llen_reg, len_reg);
        end
        else
        begin
            f_search = (llen_reg <= (n >> 1));
        end
    end

    // run scanner, one chunk of lanes per cycle
    always_comb
    begin
        logic [CW-1:0] pos;
        logic          fr;
        cs_n = cs_reg; cl_n = cl_reg; bs_n = bs_reg; bl_n = bl_reg;
        cnt_n = cnt_reg; fb_n = fb_reg; found_n = found_reg;
        es_n = es_reg; el_n = el_reg;
        for (int k = 0; k < bea_pkg::LANES; k++)
        begin
            pos = {1'b0, word_reg, chunk_reg, bea_pkg::LANE_AW'(k)};
            fr  = !buf_reg[k] && (pos < n);
            if (fr)
            begin
                if (cl_n == '0)
                begin
                    cs_n = pos;
                end
                cl_n  = cl_n + 1'b1;
                cnt_n = cnt_n + 1'b1;
                if (cl_n > bl_n)
                begin
                    bl_n = cl_n;
                    bs_n = cs_n;
                end
                if (!found_n)
                begin
                    found_n = 1'b1;
                    fb_n    = pos;
                end
                // run holding the freed range
                if ((pos >= {1'b0, start_reg}) && (cs_n <= {1'b0, start_reg}))
                begin
                    es_n = cs_n;
                    el_n = cl_n;
                end
            end
            else
            begin
                cl_n = '0;
            end
        end
    end

    assign next_base = CW'({1'b0, word_reg} + 1'b1) << bea_pkg::BIT_AW;

    always_comb
    begin
        st.op_alloc   = op_alloc;
        st.op_free    = op_free;
        st.op_rescan  = op_rescan;
        st.trivial    = (len_reg == '0);
        st.range_bad  = (end_reg > {1'b0, n});
        st.hit        = |(op_alloc ? (word_data & mask) : (~word_data & mask));
        st.word_last  = (word_reg == we);
        st.chunk_last = (chunk_reg == bea_pkg::CHUNK_AW'(bea_pkg::CHUNKS - 1));
        st.scan_last  = st.chunk_last &&
                        ((word_reg == AW'(bea_pkg::MAP_WORDS - 1)) || (next_base >= n));
        st.need_scan  = op_alloc ? (a_touch && (a_llen < (n >> 1))) : f_search;
        st.out_busy   = ov_reg && !out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gb_reg       <= bea_pkg::GROUP_DEF;
            free_reg     <= bea_pkg::GROUP_DEF;
            first_reg    <= '0;
            lbeg_reg     <= '0;
            llen_reg     <= bea_pkg::GROUP_DEF;
            sv_free_reg  <= bea_pkg::GROUP_DEF;
            sv_first_reg <= '0;
            sv_lbeg_reg  <= '0;
            sv_llen_reg  <= bea_pkg::GROUP_DEF;
            vld_reg      <= '0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                gb_reg <= cfg_wdata;
            end
            if (ram_we)
            begin
                vld_reg[word_reg] <= 1'b1;
            end
            if (cmd.act == bea_pkg::ACT_LOAD_OUT)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
            case (cmd.act)
                bea_pkg::ACT_DECODE:
                begin
                    if (op_reg == bea_pkg::OP_COMMIT)
                    begin
                        sv_free_reg  <= free_reg;
                        sv_first_reg <= first_reg;
                        sv_lbeg_reg  <= lbeg_reg;
                        sv_llen_reg  <= llen_reg;
                    end
                    else if (op_reg == bea_pkg::OP_ROLLBACK)
                    begin
                        free_reg  <= sv_free_reg;
                        first_reg <= sv_first_reg;
                        lbeg_reg  <= sv_lbeg_reg;
                        llen_reg  <= sv_llen_reg;
                    end
                end
                bea_pkg::ACT_UPDATE:
                begin
                    if (op_alloc)
                    begin
                        free_reg  <= a_free;
                        first_reg <= a_first;
                        lbeg_reg  <= a_lbeg;
                        llen_reg  <= a_llen;
                    end
                    else
                    begin
                        free_reg  <= f_free;
                        first_reg <= f_first;
                        lbeg_reg  <= f_lbeg;
                        llen_reg  <= f_llen;
                    end
                end
                bea_pkg::ACT_SCAN_END:
                begin
                    if (op_rescan)
                    begin
                        free_reg <= cnt_reg;
                        lbeg_reg <= bs_reg;
                        llen_reg <= bl_reg;
                        if (found_reg)
                        begin
                            first_reg <= fb_reg;
                        end
                    end
                    else if (op_alloc)
                    begin
                        lbeg_reg <= bs_reg;
                        llen_reg <= bl_reg;
                    end
                    else if (el_reg > llen_reg)
                    begin
                        lbeg_reg <= es_reg;
                        llen_reg <= el_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    // payload and sequencing registers
    always_ff @(posedge clk)
    begin
        if (ram_re)
        begin
            rd_vld_reg <= vld_reg[word_reg];
        end
        case (cmd.act)
            bea_pkg::ACT_ACCEPT:
            begin
                op_reg    <= op;
                start_reg <= range_start;
                len_reg   <= range_length;
                end_reg   <= {2'b0, range_start} + {1'b0, range_length};
                stat_reg  <= bea_pkg::ST_OK;
            end
            bea_pkg::ACT_DECODE:
            begin
                if ((op_alloc || op_free) && (len_reg != '0) && st.range_bad)
                begin
                    stat_reg <= bea_pkg::ST_RANGE;
                end
                word_reg  <= op_rescan ? '0 : ws;
                chunk_reg <= '0;
                cs_reg <= '0; cl_reg <= '0; bs_reg <= '0; bl_reg <= '0;
                cnt_reg <= '0; fb_reg <= '0; found_reg <= 1'b0;
                es_reg <= '0; el_reg <= '0;
            end
            bea_pkg::ACT_CHK_EV:
            begin
                if (st.hit)
                begin
                    stat_reg <= bea_pkg::ST_CONFLICT;
                end
                word_reg <= st.word_last ? ws : word_reg + 1'b1;
            end
            bea_pkg::ACT_WR_EV:
            begin
                word_reg <= word_reg + 1'b1;
            end
            bea_pkg::ACT_UPDATE:
            begin
                word_reg  <= '0;
                chunk_reg <= '0;
            end
            bea_pkg::ACT_SCAN_LD:
            begin
                buf_reg   <= word_data;
                chunk_reg <= '0;
            end
            bea_pkg::ACT_SCAN_CH:
            begin
                buf_reg   <= buf_reg >> bea_pkg::LANES;
                chunk_reg <= chunk_reg + 1'b1;
                if (st.chunk_last)
                begin
                    word_reg <= word_reg + 1'b1;
                end
                cs_reg <= cs_n; cl_reg <= cl_n; bs_reg <= bs_n; bl_reg <= bl_n;
                cnt_reg <= cnt_n; fb_reg <= fb_n; found_reg <= found_n;
                es_reg <= es_n; el_reg <= el_n;
            end
            bea_pkg::ACT_LOAD_OUT:
            begin
                o_stat_reg  <= stat_reg;
                o_free_reg  <= free_reg;
                o_first_reg <= first_reg;
                o_beg_reg   <= lbeg_reg;
                o_len_reg   <= llen_reg;
            end
            default: ;
        endcase
    end

    assign out_valid       = ov_reg;
    assign status          = o_stat_reg;
    assign free_count      = o_free_reg;
    assign first_free_hint = o_first_reg;
    assign best_start      = o_beg_reg;
    assign best_length     = o_len_reg;

endmodule

// File: hw/rtl/bitmap_extent_allocator_top.sv
// ----------------------------------------------------------------------------
// bitmap_extent_allocator_top
// Block-group allocator with bitmap, free count and largest free extent.
// ----------------------------------------------------------------------------
// usage:
//   in_ch carries one operation per beat (allocate, free, rescan, commit,
//   rollback); out_ch returns exactly one result beat per operation, with
//   the status and the four counters after it.
//   cfg_we/cfg_wdata set the group size; write it only while idle.
// sequence (one operation at a time):
//   commit, rollback, unknown op, zero length, bad range: decode, then the
//   result is loaded; the next beat is accepted when idle again
//   allocate/free: a read and an evaluate step per bitmap word touched for
//   the check pass (which stops at a conflict) and again for the write pass,
//   plus decode, update and load, plus an optional scan
//   rescan or extent search: a read, a load and chunk steps per 64-bit word
//   up to the group size; the scanner handles 8 bits per chunk step behind one RAM
//   read port
// reset: bitmap reads as all free through per-word valid flags, counters
//   go to the full-group values; no clearing pass
// stall: a result waits in the output register while the next operation is
//   accepted; that operation finishes but holds until the register frees
// ----------------------------------------------------------------------------
module bitmap_extent_allocator_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [13:0]   cfg_wdata,
    bea_in_if.sink        in_ch,
    bea_out_if.source     out_ch
);

    bea_pkg::cmd_t  cmd;
    bea_pkg::stat_t st;
    logic           in_ready;

    assign in_ch.ready = in_ready;

    bea_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    bea_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .st              (st),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .op              (in_ch.op),
        .range_start     (in_ch.range_start),
        .range_length    (in_ch.range_length),
        .out_valid       (out_ch.valid),
        .out_ready       (out_ch.ready),
        .status          (out_ch.status),
        .free_count      (out_ch.free_count),
        .first_free_hint (out_ch.first_free_hint),
        .best_start      (out_ch.best_start),
        .best_length     (out_ch.best_length)
    );

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bitmap extent allocator: a directed table of
// operations and random operation sequences, each result checked against
// a behavioral model of bitmap, counters and snapshot, with random stalls.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [1:0]  status;
        logic [13:0] free_count;
        logic [13:0] first_free;
        logic [13:0] best_start;
        logic [13:0] best_length;
    } result_t;

    typedef struct {
        logic [2:0]  op;
        logic [12:0] start;
        logic [13:0] len;
        logic        typed;
        logic [1:0]  status;
        logic [13:0] fc;
    } row_t;

    localparam int STALL_LIMIT = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [13:0] cfg_wdata = '0;

    bea_in_if  in_ch ();
    bea_out_if out_ch ();

    bitmap_extent_allocator_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_ch    (in_ch),
        .out_ch   (out_ch)
    );

    always #10 clk = ~clk;

    // allocator model state
    bit          used_map [bea_pkg::GROUP_MAX];
    int unsigned grp_reg;
    int unsigned m_free, m_first, m_bbeg, m_blen;
    int unsigned s_free, s_first, s_bbeg, s_blen;

    result_t expected_q [$];
    row_t    beat_q [$];
    int      err_count = 0;
    int      res_count = 0;
    int      idle_cycles = 0;
    bit      hold_long = 1'b0;
    bit      stim_done = 1'b0;

    function automatic int unsigned group_size();
        return grp_reg > bea_pkg::GROUP_MAX ? bea_pkg::GROUP_MAX : grp_reg;
    endfunction

    function automatic int unsigned sub_sat(int unsigned a, int unsigned b);
        return a > b ? a - b : 0;
    endfunction

    function automatic int unsigned add_sat(int unsigned a, int unsigned b);
        return a + b > 16383 ? 16383 : a + b;
    endfunction

    function automatic void longest_free(int unsigned n);
        int unsigned i, b, s, l;
        i = 0; s = 0; l = 0;
        while (i < n) begin
            if (used_map[i])
            begin
                i++;
                continue;
            end
            b = i;
            while (i < n && !used_map[i]) i++;
            if (i - b > l)
            begin
                l = i - b;
                s = b;
            end
        end
        m_bbeg = s;
        m_blen = l;
    endfunction

    function automatic void recount(int unsigned n);
        int unsigned i, b, len;
        i = 0;
        m_free = 0; m_bbeg = 0; m_blen = 0;
        while (i < n) begin
            if (used_map[i])
            begin
                i++;
                continue;
            end
            b = i;
            while (i < n && !used_map[i]) i++;
            len = i - b;
            if (m_free == 0)
            begin
                m_first = b; m_bbeg = b; m_blen = len;
            end
            else if (len > m_blen)
            begin
                m_bbeg = b; m_blen = len;
            end
            m_free = add_sat(m_free, len);
        end
    endfunction

    function automatic logic [1:0] mark_range(int unsigned st, int unsigned len,
                                              int unsigned n);
        int unsigned e, ls, ll, a, b;
        e = st + len;
        if (len == 0) return bea_pkg::ST_OK;
        if (e > n) return bea_pkg::ST_RANGE;
        for (int unsigned i = st; i < e; i++)
            if (used_map[i]) return bea_pkg::ST_CONFLICT;
        for (int unsigned i = st; i < e; i++) used_map[i] = 1'b1;
        m_free = sub_sat(m_free, len);
        ls = m_bbeg; ll = m_blen;
        if (st == ls)
        begin
            if (m_first == ls) m_first = add_sat(m_first, len);
            m_bbeg = add_sat(ls, len);
            m_blen = sub_sat(ll, len);
        end
        else if (e == ls + ll)
            m_blen = sub_sat(ll, len);
        else if (st < ls + ll && st > ls)
        begin
            a = st - ls;
            b = sub_sat(ls + ll, e);
            if (a >= b) m_blen = a;
            else
            begin
                m_blen = b;
                m_bbeg = e;
            end
        end
        else
            return bea_pkg::ST_OK;
        if (m_blen < (n >> 1)) longest_free(n);
        return bea_pkg::ST_OK;
    endfunction

    function automatic logic [1:0] clear_range(int unsigned st, int unsigned len,
                                               int unsigned n);
        int unsigned e, ne, ns;
        e = st + len;
        if (len == 0) return bea_pkg::ST_OK;
        if (e > n) return bea_pkg::ST_RANGE;
        for (int unsigned i = st; i < e; i++)
            if (!used_map[i]) return bea_pkg::ST_CONFLICT;
        for (int unsigned i = st; i < e; i++) used_map[i] = 1'b0;
        if (m_first > st) m_first = st;
        if (e == m_bbeg)
        begin
            m_bbeg = st;
            m_blen = add_sat(m_blen, len);
        end
        else if (st == m_bbeg + m_blen)
            m_blen = add_sat(m_blen, len);
        else if (m_blen <= (n >> 1))
        begin
            ne = e; ns = st;
            while (ne < n && !used_map[ne]) ne++;
            while (ns > 0 && !used_map[ns-1]) ns--;
            if (ne - ns > m_blen)
            begin
                m_blen = ne - ns;
                m_bbeg = ns;
            end
        end
        m_free = add_sat(m_free, len);
        return bea_pkg::ST_OK;
    endfunction

    function automatic result_t apply_op(logic [2:0] op, logic [12:0] st, logic [13:0] len);
        result_t r;
        int unsigned n;
        n = group_size();
        r.status = bea_pkg::ST_OK;
        case (op)
            bea_pkg::OP_ALLOC:    r.status = mark_range(st, len, n);
            bea_pkg::OP_FREE:     r.status = clear_range(st, len, n);
            bea_pkg::OP_RESCAN:   recount(n);
            bea_pkg::OP_COMMIT:
            begin
                s_free = m_free; s_first = m_first; s_bbeg = m_bbeg; s_blen = m_blen;
            end
            bea_pkg::OP_ROLLBACK:
            begin
                m_free = s_free; m_first = s_first; m_bbeg = s_bbeg; m_blen = s_blen;
            end
            default: ;
        endcase
        r.free_count  = m_free[13:0];
        r.first_free  = m_first[13:0];
        r.best_start  = m_bbeg[13:0];
        r.best_length = m_blen[13:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        err_count++;
        $display("mismatch at result %0d: %s got %0d expected %0d",
                 res_count, what, got, want);
    endtask

    task automatic add_row(logic [2:0] op, int unsigned st, int unsigned len);
        row_t r;
        r.op = op; r.start = st[12:0]; r.len = len[13:0]; r.typed = 1'b0;
        r.status = bea_pkg::ST_OK; r.fc = '0;
        beat_q.push_back(r);
    endtask

    task automatic add_typed(logic [2:0] op, int unsigned st, int unsigned len,
                             logic [1:0] status, int unsigned fc);
        row_t r;
        r.op = op; r.start = st[12:0]; r.len = len[13:0]; r.typed = 1'b1;
        r.status = status; r.fc = fc[13:0];
        beat_q.push_back(r);
    endtask

    // send one beat with a random gap before it; valid stays up after
    // the accepting edge until the next gap or the next beat
    task automatic send_beat(row_t r);
        result_t p;
        int gap;
        gap = $urandom_range(0, 12);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.op           <= r.op;
        in_ch.range_start  <= r.start;
        in_ch.range_length <= r.len;
        do @(posedge clk); while (!in_ch.ready);
        p = apply_op(r.op, r.start, r.len);
        if (r.typed && (p.status != r.status || p.free_count != r.fc))
            $display("note: table row disagrees with prediction");
        if (r.typed)
        begin
            p.status = r.status;
            p.free_count = r.fc;
        end
        expected_q.push_back(p);
    endtask

    task automatic drain_and_config(int unsigned v);
        in_ch.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v[13:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        grp_reg = v;
    endtask

    task automatic random_phase(int items);
        int unsigned n, st, len, k;
        row_t r;
        n = group_size();
        for (int i = 0; i < items; i++) begin
            k = $urandom_range(0, 99);
            r.typed = 1'b0; r.status = bea_pkg::ST_OK; r.fc = '0;
            if (k < 42 || k < 80)
            begin
                r.op = (k < 42) ? bea_pkg::OP_ALLOC : bea_pkg::OP_FREE;
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 16383)
                                                  : $urandom_range(1, 40);
                st = (len < n && $urandom_range(0, 5) != 0) ? $urandom_range(0, n - 1)
                                                            : $urandom_range(0, 8191);
                if (st + len > n && $urandom_range(0, 2) != 0 && len <= n)
                    st = n - len;
                r.start = st[12:0];
                r.len = len[13:0];
            end
            else
            begin
                r.op = (k < 88) ? bea_pkg::OP_RESCAN : (k < 93) ? bea_pkg::OP_COMMIT
                     : (k < 97) ? bea_pkg::OP_ROLLBACK : 3'($urandom_range(5, 7));
                r.start = 13'($urandom);
                r.len = 14'($urandom);
            end
            send_beat(r);
        end
    endtask

    // input driver
    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.op = '0;
        in_ch.range_start = '0;
        in_ch.range_length = '0;
        grp_reg = bea_pkg::GROUP_DEF;
        foreach (used_map[i]) used_map[i] = 1'b0;
        m_free = bea_pkg::GROUP_MAX; m_first = 0; m_bbeg = 0; m_blen = bea_pkg::GROUP_MAX;
        s_free = m_free; s_first = 0; s_bbeg = 0; s_blen = m_blen;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        add_typed(bea_pkg::OP_COMMIT,   0, 0,     bea_pkg::ST_OK,       8192);
        add_typed(bea_pkg::OP_ALLOC,    0, 0,     bea_pkg::ST_OK,       8192);
        add_typed(bea_pkg::OP_ALLOC,    8191, 2,  bea_pkg::ST_RANGE,    8192);
        add_typed(bea_pkg::OP_ALLOC,    0, 16383, bea_pkg::ST_RANGE,    8192);
        add_typed(bea_pkg::OP_FREE,     5, 1,     bea_pkg::ST_CONFLICT, 8192);
        add_typed(bea_pkg::OP_ALLOC,    0, 8,     bea_pkg::ST_OK,       8184);
        add_typed(bea_pkg::OP_ALLOC,    4, 2,     bea_pkg::ST_CONFLICT, 8184);
        add_row(bea_pkg::OP_ALLOC,    8191, 1);
        add_row(bea_pkg::OP_ALLOC,    100, 4000);
        add_row(bea_pkg::OP_ALLOC,    5000, 10);
        add_row(bea_pkg::OP_FREE,     100, 50);
        add_row(bea_pkg::OP_FREE,     150, 3950);
        add_row(bea_pkg::OP_FREE,     0, 8);
        add_row(bea_pkg::OP_RESCAN,   0, 0);
        add_typed(bea_pkg::OP_ROLLBACK, 0, 0,     bea_pkg::ST_OK,       8192);
        add_row(bea_pkg::OP_RESCAN,   0, 0);
        add_row(3'd5,                 8191, 16383);
        add_row(3'd7,                 0, 0);
        add_row(bea_pkg::OP_FREE,     5000, 10);
        add_row(bea_pkg::OP_FREE,     8191, 1);
        add_row(bea_pkg::OP_ALLOC,    0, 8192);
        add_row(bea_pkg::OP_RESCAN,   0, 0);
        add_typed(bea_pkg::OP_FREE,   0, 8192,    bea_pkg::ST_OK,       8192);
        add_row(bea_pkg::OP_RESCAN,   0, 0);
        foreach (beat_q[i]) send_beat(beat_q[i]);

        random_phase(130);
        // long receiver hold while beats keep coming
        hold_long = 1'b1;
        random_phase(20);
        hold_long = 1'b0;

        drain_and_config(1);
        add_row(bea_pkg::OP_RESCAN, 0, 0);
        beat_q.delete();
        add_row(bea_pkg::OP_RESCAN, 0, 0);
        send_beat(beat_q[0]);
        random_phase(30);

        drain_and_config(97);
        send_beat(beat_q[0]);
        random_phase(80);

        drain_and_config(16383);
        random_phase(20);
        send_beat(beat_q[0]);
        random_phase(40);

        drain_and_config(8192);
        send_beat(beat_q[0]);
        random_phase(60);
        in_ch.valid <= 1'b0;
        stim_done = 1'b1;
    end

    // result sink with random stalls
    initial
    begin
        int gap;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            gap = $urandom_range(0, 12);
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (hold_long) gap = 3000;
            if (gap != 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        result_t e;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_q.size() == 0)
                report_mismatch("unexpected beat", 1, 0);
            else
            begin
                e = expected_q.pop_front();
                if (out_ch.status != e.status)
                    report_mismatch("status", out_ch.status, e.status);
                if (out_ch.free_count != e.free_count)
                    report_mismatch("free_count", out_ch.free_count, e.free_count);
                if (out_ch.first_free_hint != e.first_free)
                    report_mismatch("first_free_hint", out_ch.first_free_hint, e.first_free);
                if (out_ch.best_start != e.best_start)
                    report_mismatch("best_start", out_ch.best_start, e.best_start);
                if (out_ch.best_length != e.best_length)
                    report_mismatch("best_length", out_ch.best_length, e.best_length);
            end
            res_count++;
        end
    end

    // watchdog and end of run
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("watchdog expired with %0d results pending", expected_q.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        wait (stim_done);
        while (expected_q.size() != 0) @(posedge clk);
        repeat (1500) @(posedge clk);
        $display("checked %0d results over allocate, free, rescan, commit and rollback",
                 res_count);
        $display("group sizes 8192, 1, 97 and an oversize setting; %0d mismatches", err_count);
        if (err_count == 0 && expected_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

// File: sim.f
hw/rtl/bea_pkg.sv
hw/rtl/bea_if.sv
hw/rtl/bea_ram.sv
hw/rtl/bea_ctrl.sv
hw/rtl/bea_dp.sv
hw/rtl/bitmap_extent_allocator_top.sv
sim/tb.sv
